### rtl/integer_to_nibble_digits_macros.svh
// Assertion macros for the integer_to_nibble_digits top level.
`ifndef INTEGER_TO_NIBBLE_DIGITS_MACROS_SVH
`define INTEGER_TO_NIBBLE_DIGITS_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define ITN_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("itn check failed: same-cycle implication");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define ITN_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("itn check failed: next-cycle implication");

`endif

### rtl/itn_pkg.sv
// Types, constants and command structs for the integer to nibble digit converter.
package itn_pkg;

    // Field widths and digit limits
    localparam int VALUE_W    = 64;
    localparam int STEP_BITS  = 8;
    localparam int DIV_STEPS  = VALUE_W / STEP_BITS;
    localparam int STEP_CNT_W = $clog2(DIV_STEPS);
    localparam int MAX_DIGITS = 16;
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
    localparam int CMP_W      = (CNT_W > 5) ? CNT_W : 5;

    // Valid radix range
    localparam logic [4:0] RADIX_MIN = 5'd2;
    localparam logic [4:0] RADIX_MAX = 5'd16;

    // Result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_RADIX = 2'd1;
    localparam logic [1:0] STATUS_EMPTY     = 2'd2;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [4:0]         radix;
        logic [4:0]         digit_count;
        logic [7:0]         start_offset;
    } t_in_item;

    typedef struct packed {
        logic [3:0] digit;
        logic [8:0] nibble_position;
        logic       last_digit;
        logic [1:0] status;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic load;    // capture a new input item
        logic step;    // one division step (STEP_BITS quotient bits)
        logic finish;  // last step of a digit: register the result
        logic next;    // advance to the next digit
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic special;  // input item gives a single status-only result
        logic last;     // registered result is the last one of its item
    } t_dp_status;

endpackage

### rtl/itn_datapath.sv
// Datapath: value shift register, narrow long-division unit and result register.
module itn_datapath (
    input  logic                  i_clk,
    input  itn_pkg::t_in_item     i_in_data,
    input  itn_pkg::t_dp_cmd      i_cmd,
    output itn_pkg::t_dp_status   o_status,
    output itn_pkg::t_out_item    o_out_data
);

    logic [itn_pkg::VALUE_W-1:0]   r_work;
    logic [3:0]                    r_rem;
    logic [4:0]                    r_radix;
    logic [7:0]                    r_offset;
    logic [itn_pkg::CNT_W-1:0]     r_index;
    logic [itn_pkg::CNT_W-1:0]     r_count;
    itn_pkg::t_out_item            r_out;

    logic                          in_bad_radix;
    logic                          in_zero;
    logic [itn_pkg::CMP_W-1:0]     cnt_ext;
    logic [itn_pkg::CNT_W-1:0]     cnt_sat;
    logic [3:0]                    n_rem;
    logic [itn_pkg::STEP_BITS-1:0] q_bits;
    logic                          is_last;
    logic [8:0]                    position;

    // Input checks and digit count saturation
    always_comb begin
        in_bad_radix = (i_in_data.radix < itn_pkg::RADIX_MIN) ||
                       (i_in_data.radix > itn_pkg::RADIX_MAX);
        in_zero      = (i_in_data.digit_count == 5'd0);
        cnt_ext      = itn_pkg::CMP_W'(i_in_data.digit_count);
        if (cnt_ext > itn_pkg::CMP_W'(itn_pkg::MAX_DIGITS)) begin
            cnt_sat = itn_pkg::CNT_W'(itn_pkg::MAX_DIGITS);
        end else begin
            cnt_sat = itn_pkg::CNT_W'(cnt_ext);
        end
    end

    // STEP_BITS restoring division steps by the radix, MSB first
    always_comb begin
        logic [4:0] part;
        logic [3:0] rem_v;
        rem_v  = r_rem;
        part   = 5'd0;
        q_bits = '0;
        for (int k = 0; k < itn_pkg::STEP_BITS; k++) begin
            part = {rem_v, r_work[itn_pkg::VALUE_W-1-k]};
            if (part >= r_radix) begin
                q_bits[itn_pkg::STEP_BITS-1-k] = 1'b1;
                rem_v = 4'(part - r_radix);
            end else begin
                rem_v = part[3:0];
            end
        end
        n_rem = rem_v;
    end

    assign is_last  = (itn_pkg::CNT_W'(r_index + 1'b1) == r_count);
    assign position = 9'(r_offset) + 9'(r_index);

    // Working registers and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_work   <= i_in_data.value;
            r_rem    <= 4'd0;
            r_radix  <= i_in_data.radix;
            r_offset <= i_in_data.start_offset;
            r_index  <= '0;
            r_count  <= cnt_sat;
            if (in_bad_radix) begin
                r_out <= '{digit: 4'd0, nibble_position: 9'd0, last_digit: 1'b1,
                           status: itn_pkg::STATUS_BAD_RADIX};
            end else if (in_zero) begin
                r_out <= '{digit: 4'd0, nibble_position: 9'd0, last_digit: 1'b1,
                           status: itn_pkg::STATUS_EMPTY};
            end
        end else if (i_cmd.step) begin
            r_work <= {r_work[itn_pkg::VALUE_W-itn_pkg::STEP_BITS-1:0], q_bits};
            r_rem  <= n_rem;
            if (i_cmd.finish) begin
                r_out <= '{digit: n_rem, nibble_position: position, last_digit: is_last,
                           status: itn_pkg::STATUS_OK};
            end
        end else if (i_cmd.next) begin
            r_index <= itn_pkg::CNT_W'(r_index + 1'b1);
            r_rem   <= 4'd0;
        end
    end

    assign o_status.special = in_bad_radix || in_zero;
    assign o_status.last    = r_out.last_digit;
    assign o_out_data       = r_out;

endmodule

### rtl/itn_ctrl.sv
// Controller: sequences load, division steps and result transfers.
module itn_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_out_ready,
    input  itn_pkg::t_dp_status  i_status,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    output itn_pkg::t_dp_cmd     o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EMIT
    } t_state;

    t_state                         r_state, n_state;
    logic                           r_out_valid, n_out_valid;
    logic [itn_pkg::STEP_CNT_W-1:0] r_step_cnt, n_step_cnt;
    logic                           step_end;

    assign step_end = (r_step_cnt == itn_pkg::STEP_CNT_W'(itn_pkg::DIV_STEPS - 1));

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_step_cnt  = r_step_cnt;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_step_cnt = '0;
                    if (i_status.special) begin
                        n_state     = S_EMIT;
                        n_out_valid = 1'b1;
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                o_cmd.step   = 1'b1;
                o_cmd.finish = step_end;
                n_step_cnt   = itn_pkg::STEP_CNT_W'(r_step_cnt + 1'b1);
                if (step_end) begin
                    n_state     = S_EMIT;
                    n_out_valid = 1'b1;
                end
            end
            S_EMIT: begin
                if (i_out_ready) begin
                    n_out_valid = 1'b0;
                    n_step_cnt  = '0;
                    if (i_status.last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.next = 1'b1;
                        n_state    = S_DIV;
                    end
                end
            end
            default: begin
                n_state     = S_IDLE;
                n_out_valid = 1'b0;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_step_cnt  <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_step_cnt  <= n_step_cnt;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### rtl/integer_to_nibble_digits.sv
// Top level of the integer to nibble digit converter.
//
// Input channel (i_in_valid / o_in_ready / i_in_data): one item carries a
// 64-bit value, a radix, a digit count and a start nibble position. Output
// channel (o_out_valid / i_out_ready / o_out_data): one transfer per digit,
// least significant first, with nibble position, last mark and status.
// A bad radix or a zero digit count gives one status-only transfer, valid
// the cycle after the input transfer. Otherwise each digit comes from long
// division (8 quotient bits per cycle over 64 bits, by a single narrow
// restoring divider); the first digit's division starts after the input
// transfer and each later digit's after the previous digit's transfer.
// One item is in flight at a time: o_in_ready is high only while idle.
// A stalled receiver holds the result register and the whole block until
// the transfer. Synchronous active-low reset returns to idle with no result
// pending.
`include "integer_to_nibble_digits_macros.svh"

module integer_to_nibble_digits (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  itn_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output itn_pkg::t_out_item  o_out_data
);

    itn_pkg::t_dp_cmd    dp_cmd;
    itn_pkg::t_dp_status dp_status;

    logic                in_bad_radix_xfer;
    logic                out_xfer_more;
    logic                out_status_only;

    itn_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .i_status    (dp_status),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (dp_cmd)
    );

    itn_datapath u_datapath (
        .i_clk      (i_clk),
        .i_in_data  (i_in_data),
        .i_cmd      (dp_cmd),
        .o_status   (dp_status),
        .o_out_data (o_out_data)
    );

    // Terms used by the checks
    assign in_bad_radix_xfer = i_in_valid && o_in_ready &&
                               ((i_in_data.radix < itn_pkg::RADIX_MIN) ||
                                (i_in_data.radix > itn_pkg::RADIX_MAX));
    assign out_xfer_more     = o_out_valid && i_out_ready && !o_out_data.last_digit;
    assign out_status_only   = o_out_valid && (o_out_data.status != itn_pkg::STATUS_OK);

    // Checks
    `ITN_ASSERT_IMPLIES(a_one_item_at_a_time, o_out_valid, !o_in_ready)
    `ITN_ASSERT_NEXT(a_bad_radix_result, in_bad_radix_xfer, o_out_valid && (o_out_data.status == itn_pkg::STATUS_BAD_RADIX))
    `ITN_ASSERT_NEXT(a_more_digits_follow, out_xfer_more, !o_in_ready && !o_out_valid)
    `ITN_ASSERT_IMPLIES(a_status_only_is_last, out_status_only, o_out_data.last_digit)

endmodule

### test/integer_to_nibble_digits_test.sv
// Self-checking testbench for the integer to nibble digit converter.
module integer_to_nibble_digits_test;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 4;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 24;
    localparam int TIMEOUT_CYCLES = 1_000_000;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               i_out_ready = 1'b0;
    itn_pkg::t_in_item  i_in_data   = '0;
    logic               o_in_ready;
    logic               o_out_valid;
    itn_pkg::t_out_item o_out_data;

    // Digits still owed by the block, oldest first
    itn_pkg::t_out_item pending_digits[$];

    bit idle_enabled    = 1'b0;
    int error_count     = 0;
    int items_sent      = 0;
    int digits_checked  = 0;
    int bad_radix_items = 0;
    int empty_items     = 0;
    int hold_requests   = 0;
    int holds_started   = 0;

    integer_to_nibble_digits i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Expected digit transfers for one accepted item
    function automatic void predict_digits(input itn_pkg::t_in_item item);
        logic [63:0]        rest;
        logic [63:0]        base;
        logic [63:0]        rem;
        int unsigned        ndig;
        itn_pkg::t_out_item res;
        base = {59'd0, item.radix};
        ndig = 32'(item.digit_count);
        rest = item.value;
        if (ndig > itn_pkg::MAX_DIGITS) ndig = itn_pkg::MAX_DIGITS;
        // radix check wins over the zero count check
        if (item.radix < itn_pkg::RADIX_MIN || item.radix > itn_pkg::RADIX_MAX) begin
            res = '{digit: 4'd0, nibble_position: 9'd0, last_digit: 1'b1,
                    status: itn_pkg::STATUS_BAD_RADIX};
            pending_digits.push_back(res);
            bad_radix_items++;
        end else if (ndig == 0) begin
            res = '{digit: 4'd0, nibble_position: 9'd0, last_digit: 1'b1,
                    status: itn_pkg::STATUS_EMPTY};
            pending_digits.push_back(res);
            empty_items++;
        end else begin
            for (int unsigned k = 0; k < ndig; k++) begin
                rem = rest % base;
                res.digit           = rem[3:0];
                res.nibble_position = {1'b0, item.start_offset} + 9'(k);
                res.last_digit      = (k == ndig - 1);
                res.status          = itn_pkg::STATUS_OK;
                pending_digits.push_back(res);
                rest = rest / base;
            end
        end
    endfunction

    function automatic itn_pkg::t_in_item make_item(input logic [63:0] value,
                                                    input logic [4:0] radix,
                                                    input logic [4:0] count,
                                                    input logic [7:0] offset);
        itn_pkg::t_in_item item;
        item.value        = value;
        item.radix        = radix;
        item.digit_count  = count;
        item.start_offset = offset;
        return item;
    endfunction

    // Weighted toward valid radix and nonzero count, with some noise
    function automatic itn_pkg::t_in_item random_item();
        logic [63:0] wide;
        logic [63:0] value;
        logic [4:0]  radix;
        logic [4:0]  count;
        wide = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: value = wide;
            1: value = 64'($urandom_range(0, 999));
            2: value = {32'd0, $urandom};
            default: value = wide >> $urandom_range(0, 63);
        endcase
        if ($urandom_range(0, 9) == 0) radix = 5'($urandom_range(0, 31));
        else radix = 5'($urandom_range(2, 16));
        if ($urandom_range(0, 19) == 0) count = 5'($urandom_range(0, 31));
        else count = 5'($urandom_range(1, 16));
        return make_item(value, radix, count, 8'($urandom_range(0, 255)));
    endfunction

    // Offer one item and wait for its transfer; valid stays up on return
    task automatic send_item(input itn_pkg::t_in_item item);
        int gap;
        if (idle_enabled && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        predict_digits(item);
        items_sent++;
    endtask

    // Stop offering and wait until every owed digit has been seen
    task automatic drain_digits();
        i_in_valid <= 1'b0;
        while (pending_digits.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Receiver: check each transfer, then pick ready for the next cycle
    always @(posedge i_clk) begin
        itn_pkg::t_out_item want;
        static int stall_left = 0;
        static int hold_left  = 0;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                digits_checked++;
                if (pending_digits.size() == 0) begin
                    $error("unexpected transfer: digit %0d position %0d status %0d",
                           o_out_data.digit, o_out_data.nibble_position,
                           o_out_data.status);
                    error_count++;
                end else begin
                    want = pending_digits.pop_front();
                    if (o_out_data.digit !== want.digit) begin
                        $error("digit: expected %0d, got %0d",
                               want.digit, o_out_data.digit);
                        error_count++;
                    end
                    if (o_out_data.nibble_position !== want.nibble_position) begin
                        $error("nibble_position: expected %0d, got %0d",
                               want.nibble_position, o_out_data.nibble_position);
                        error_count++;
                    end
                    if (o_out_data.last_digit !== want.last_digit) begin
                        $error("last_digit: expected %0d, got %0d",
                               want.last_digit, o_out_data.last_digit);
                        error_count++;
                    end
                    if (o_out_data.status !== want.status) begin
                        $error("status: expected %0d, got %0d",
                               want.status, o_out_data.status);
                        error_count++;
                    end
                end
            end
            // long hold-off first, then short random stalls
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (holds_started < hold_requests) begin
                holds_started++;
                hold_left = HOLD_CYCLES - 1;
                i_out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (idle_enabled && $urandom_range(0, 3) == 0) begin
                stall_left = $urandom_range(0, 2);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Field extremes, radix limits and every special status
    task automatic test_directed_corners();
        idle_enabled = 1'b1;
        send_item(make_item(64'd0, 5'd10, 5'd1, 8'd0));
        send_item(make_item('1, 5'd16, 5'd16, 8'd255));
        send_item(make_item('1, 5'd2, 5'd16, 8'd0));
        send_item(make_item('1, 5'd3, 5'd16, 8'd128));
        send_item(make_item(64'h8000_0000_0000_0000, 5'd15, 5'd16, 8'd17));
        // invalid radix, including with a zero count
        send_item(make_item(64'd123, 5'd0, 5'd5, 8'd9));
        send_item(make_item(64'd123, 5'd1, 5'd5, 8'd9));
        send_item(make_item(64'd123, 5'd17, 5'd5, 8'd9));
        send_item(make_item('1, 5'd31, 5'd0, 8'd255));
        // zero count with a valid radix
        send_item(make_item(64'd55, 5'd10, 5'd0, 8'd40));
        // count above the limit saturates
        send_item(make_item(64'h0123_4567_89ab_cdef, 5'd16, 5'd31, 8'd250));
        send_item(make_item(64'd987654321, 5'd10, 5'd17, 8'd1));
        // value wider than the count: high digits dropped
        send_item(make_item(64'd12345, 5'd10, 5'd2, 8'd60));
        // value narrower than the count: zero fill
        send_item(make_item(64'd7, 5'd10, 5'd8, 8'd200));
        send_item(make_item(64'h5555_aaaa_5555_aaaa, 5'd8, 5'd16, 8'd255));
        send_item(make_item(64'd1, 5'd7, 5'd16, 8'haa));
        drain_digits();
    endtask

    // Bulk random items with idling on both sides
    task automatic test_random_digits();
        idle_enabled = 1'b1;
        repeat (260) send_item(random_item());
        drain_digits();
    endtask

    // Receiver holds off while the sender keeps offering items
    task automatic test_receiver_backpressure();
        idle_enabled = 1'b1;
        hold_requests++;
        repeat (15) send_item(random_item());
        drain_digits();
    endtask

    // Last stretch runs back to back with no idling
    task automatic test_steady_stream();
        idle_enabled = 1'b0;
        repeat (80) send_item(random_item());
        drain_digits();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_corners();
        test_random_digits();
        test_receiver_backpressure();
        test_steady_stream();
        $display("%0d items sent, %0d digit transfers checked", items_sent, digits_checked);
        $display("%0d bad-radix items, %0d empty items, %0d long receiver hold-offs",
                 bad_radix_items, empty_items, holds_started);
        if (error_count == 0) begin
            $display("integer_to_nibble_digits_test: done, clean");
        end else begin
            $display("integer_to_nibble_digits_test: done, errors");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("timeout with %0d digits outstanding", pending_digits.size());
        $display("integer_to_nibble_digits_test: done, errors");
        $finish;
    end

endmodule
